// ----- rtl/u8cp_pkg.sv -----
// ----------------------------------------------------------------------------
// u8cp_pkg: shared types and functions for the utf-8 to cp866 recoder
// Holds the decoder state encoding, the queue entry layout and the
// code point mapping used by the front and back parts.
// ----------------------------------------------------------------------------
package u8cp_pkg;

    // queue between front and back
    localparam int FifoDepth = 4;
    localparam int FifoAw    = $clog2(FifoDepth);

    localparam logic [7:0] QMark = 8'h3F;

    // pending sequence kind, one-hot
    typedef enum logic [3:0] {
        KIND_NONE  = 4'b0001,
        KIND_TWO   = 4'b0010,
        KIND_THREE = 4'b0100,
        KIND_FOUR  = 4'b1000
    } seq_kind_t;

    // outcome of decoding a byte with nothing pending
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        seq_kind_t  kind;
        logic [1:0] rem;
        logic [15:0] code;
    } fresh_t;

    // one queue entry: one or two results caused by one input beat
    // a single result sits in second; last marks the final result
    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
        logic       last;
    } res_pair_t;

    // decode a nonzero byte with no sequence pending
    function automatic fresh_t decode_fresh(input logic [7:0] b);
        fresh_t f;
        f.emit = 1'b0;
        f.data = QMark;
        f.kind = KIND_NONE;
        f.rem  = 2'd0;
        f.code = 16'h0000;
        if (!b[7]) begin
            f.emit = 1'b1;
            f.data = b;
        end else if (b[7:5] == 3'b110) begin
            f.kind = KIND_TWO;
            f.rem  = 2'd1;
            f.code = {11'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            f.kind = KIND_THREE;
            f.rem  = 2'd2;
            f.code = {12'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            f.emit = 1'b1;
            f.kind = KIND_FOUR;
            f.rem  = 2'd3;
        end else begin
            f.emit = 1'b1;
        end
        return f;
    endfunction

    // map a 16-bit code point to cp866
    function automatic logic [7:0] map_code(input logic [15:0] cp);
        logic [7:0] r;
        r = QMark;
        if (cp[15:4] == 12'h041) begin
            r = {4'h8, cp[3:0]};
        end else if (cp[15:4] == 12'h042) begin
            r = {4'h9, cp[3:0]};
        end else if (cp[15:4] == 12'h043) begin
            r = {4'hA, cp[3:0]};
        end else if (cp[15:4] == 12'h044) begin
            r = {4'hE, cp[3:0]};
        end else if (cp == 16'h0401) begin
            r = 8'hF0;
        end else if (cp == 16'h0451) begin
            r = 8'hF1;
        end else if (cp == 16'h00A0) begin
            r = 8'h20;
        end else if (cp == 16'h2013 || cp == 16'h2014) begin
            r = 8'h2D;
        end else if (cp == 16'h2018 || cp == 16'h2019) begin
            r = 8'h27;
        end else if (cp == 16'h201C || cp == 16'h201D) begin
            r = 8'h22;
        end else if (cp == 16'h2026) begin
            r = 8'h2E;
        end else if (cp[15:7] == 9'd0) begin
            r = cp[7:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/utf8_to_cp866_stream_recoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_cp866_stream_recoder: utf-8 byte stream to cp866 byte stream
// Each result is stored in a queue entry and then in the output register.
// Throughput: one input beat per cycle while the queue has room; one result
// beat per cycle while m_tready is high; a two-result beat gives two beats.
// Reset: synchronous aresetn clears the decoder state, queue and output.
// ----------------------------------------------------------------------------
module utf8_to_cp866_stream_recoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // end_of_string
);

    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    u8cp_pkg::res_pair_t push_data;
    u8cp_pkg::res_pair_t pop_data;

    // decoder front
    u8cp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .fifo_full (full),
        .in_ready  (s_tready),
        .push      (push),
        .push_data (push_data)
    );

    // result queue
    u8cp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // output serializer
    u8cp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (empty),
        .fifo_data  (pop_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

// ----- rtl/u8cp_front.sv -----
// ----------------------------------------------------------------------------
// u8cp_front: utf-8 sequence decoder
// Takes one input beat per cycle while the queue is not full, tracks the
// pending sequence and pushes each beat's results into the queue as one entry.
// ----------------------------------------------------------------------------
module u8cp_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [7:0]            in_data,
    input  logic                  fifo_full,
    output logic                  in_ready,
    output logic                  push,
    output u8cp_pkg::res_pair_t   push_data
);

    u8cp_pkg::seq_kind_t kind_reg, kind_next;
    logic [1:0]          rem_reg, rem_next;
    logic [15:0]         code_reg, code_next;

    logic                accept;
    logic                pending;
    logic                cont;
    logic                emit;
    logic [1:0]          rem_dec;
    logic [15:0]         code_shift;
    u8cp_pkg::fresh_t    fr;
    u8cp_pkg::res_pair_t ent;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;
    assign pending  = (kind_reg != u8cp_pkg::KIND_NONE) && (rem_reg != 2'd0);
    assign cont     = (in_data[7:6] == 2'b10);
    assign fr       = u8cp_pkg::decode_fresh(in_data);
    assign rem_dec  = rem_reg - 2'd1;
    assign code_shift = {code_reg[9:0], in_data[5:0]};

    // next state and emitted results for the current beat
    always_comb begin
        kind_next = kind_reg;
        rem_next  = rem_reg;
        code_next = code_reg;
        emit      = 1'b0;
        ent.two    = 1'b0;
        ent.first  = u8cp_pkg::QMark;
        ent.second = u8cp_pkg::QMark;
        ent.last   = 1'b0;
        if (in_data == 8'd0) begin
            // terminator closes the string
            emit       = 1'b1;
            ent.two    = pending && (kind_reg != u8cp_pkg::KIND_FOUR);
            ent.second = 8'd0;
            ent.last   = 1'b1;
            kind_next  = u8cp_pkg::KIND_NONE;
            rem_next   = 2'd0;
            code_next  = 16'h0000;
        end else if (!pending) begin
            emit       = fr.emit;
            ent.second = fr.data;
            kind_next  = fr.kind;
            rem_next   = fr.rem;
            code_next  = fr.code;
        end else if (cont) begin
            // continuation byte
            if (kind_reg == u8cp_pkg::KIND_FOUR) begin
                rem_next = rem_dec;
                if (rem_dec == 2'd0) begin
                    kind_next = u8cp_pkg::KIND_NONE;
                    code_next = 16'h0000;
                end
            end else if (rem_dec == 2'd0) begin
                emit       = 1'b1;
                ent.second = u8cp_pkg::map_code(code_shift);
                kind_next  = u8cp_pkg::KIND_NONE;
                rem_next   = 2'd0;
                code_next  = 16'h0000;
            end else begin
                rem_next  = rem_dec;
                code_next = code_shift;
            end
        end else begin
            // truncated sequence, then decode the byte afresh
            kind_next = fr.kind;
            rem_next  = fr.rem;
            code_next = fr.code;
            if (kind_reg != u8cp_pkg::KIND_FOUR) begin
                emit       = 1'b1;
                ent.two    = fr.emit;
                ent.second = fr.emit ? fr.data : u8cp_pkg::QMark;
            end else begin
                emit       = fr.emit;
                ent.second = fr.data;
            end
        end
    end

    assign push      = accept && emit;
    assign push_data = ent;

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= u8cp_pkg::KIND_NONE;
            rem_reg  <= 2'd0;
            code_reg <= 16'h0000;
        end else if (accept) begin
            kind_reg <= kind_next;
            rem_reg  <= rem_next;
            code_reg <= code_next;
        end
    end

    // a nonzero count always belongs to a sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg != 2'd0) |-> (kind_reg != u8cp_pkg::KIND_NONE))
        else $error("remaining count without a pending sequence");

endmodule

// ----- rtl/u8cp_fifo.sv -----
// ----------------------------------------------------------------------------
// u8cp_fifo: short queue of result entries
// Decouples the decoder from the output side so each can stall alone.
// ----------------------------------------------------------------------------
module u8cp_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  u8cp_pkg::res_pair_t   push_data,
    output logic                  full,
    input  logic                  pop,
    output u8cp_pkg::res_pair_t   pop_data,
    output logic                  empty
);

    u8cp_pkg::res_pair_t           mem_reg [u8cp_pkg::FifoDepth];
    logic [u8cp_pkg::FifoAw-1:0]   wr_ptr_reg;
    logic [u8cp_pkg::FifoAw-1:0]   rd_ptr_reg;
    logic [u8cp_pkg::FifoAw:0]     count_reg, count_next;

    assign full     = (count_reg == (u8cp_pkg::FifoAw+1)'(u8cp_pkg::FifoDepth));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) full |-> !push)
        else $error("push into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn) empty |-> !pop)
        else $error("pop from an empty queue");

endmodule

// ----- rtl/u8cp_back.sv -----
// ----------------------------------------------------------------------------
// u8cp_back: output serializer
// Pops queue entries and sends their one or two results one beat at a time
// from an output register.
// ----------------------------------------------------------------------------
module u8cp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fifo_empty,
    input  u8cp_pkg::res_pair_t   fifo_data,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_data,
    output logic                  out_last
);

    logic       hv_reg;
    logic       two_reg;
    logic [7:0] cur_reg;
    logic [7:0] sec_reg;
    logic       last_reg;
    logic       taken;

    assign taken     = hv_reg && out_ready;
    assign pop       = !fifo_empty && (!hv_reg || (taken && !two_reg));
    assign out_valid = hv_reg;
    assign out_data  = cur_reg;
    assign out_last  = last_reg && !two_reg;

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg  <= 1'b0;
            two_reg <= 1'b0;
        end else if (pop) begin
            hv_reg  <= 1'b1;
            two_reg <= fifo_data.two;
        end else if (taken) begin
            hv_reg  <= two_reg;
            two_reg <= 1'b0;
        end
    end

    // result bytes
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg  <= fifo_data.two ? fifo_data.first : fifo_data.second;
            sec_reg  <= fifo_data.second;
            last_reg <= fifo_data.last;
        end else if (taken && two_reg) begin
            cur_reg <= sec_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) two_reg |-> hv_reg)
        else $error("second result pending with output register empty");

endmodule

// ----- test/cp866_stream_checker.sv -----
// ----------------------------------------------------------------------------
// cp866_stream_checker: scoreboard for the utf-8 to cp866 recoder
// Watches the input and result channels and keeps its own decoder state.
// Each accepted input beat adds the cp866 bytes it should cause to a queue.
// Each accepted result beat is compared with the oldest queued byte.
// ----------------------------------------------------------------------------
module cp866_stream_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,   // end_of_string
    output int         err_count,
    output int         outstanding,
    output int         results_seen,
    output int         strings_seen
);

    localparam logic [7:0] EndByte   = 8'h00;
    localparam int         MaxPrints = 20;

    typedef struct packed {
        logic [7:0] cp866;
        logic       eos;
    } cp866_beat_t;

    cp866_beat_t cp866_expected [$];
    cp866_beat_t want;

    // decoder state as seen by the scoreboard
    u8cp_pkg::seq_kind_t seq_kind;
    logic [1:0]          cont_left;
    logic [15:0]         code_acc;

    initial begin
        err_count    = 0;
        outstanding  = 0;
        results_seen = 0;
        strings_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MaxPrints)
            $display("mismatch at beat %0d: %s", results_seen, msg);
        err_count++;
    endtask

    // cp866 byte for a 16-bit code point
    function automatic logic [7:0] cp866_of(input logic [15:0] cp);
        // capital A through small pe are one contiguous run
        if (cp >= 16'h0410 && cp <= 16'h043F)
            return 8'h80 + 8'(cp - 16'h0410);
        if (cp >= 16'h0440 && cp <= 16'h044F)
            return 8'hE0 + 8'(cp - 16'h0440);
        case (cp)
            16'h0401:           return 8'hF0;
            16'h0451:           return 8'hF1;
            16'h00A0:           return 8'h20;
            16'h2013, 16'h2014: return 8'h2D;
            16'h2018, 16'h2019: return 8'h27;
            16'h201C, 16'h201D: return 8'h22;
            16'h2026:           return 8'h2E;
            default:            ;
        endcase
        if (cp < 16'h0080)
            return cp[7:0];
        return u8cp_pkg::QMark;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic eos);
        cp866_beat_t e;
        e.cp866 = b;
        e.eos   = eos;
        cp866_expected.push_back(e);
    endtask

    task automatic clear_decoder();
        seq_kind  = u8cp_pkg::KIND_NONE;
        cont_left = 2'd0;
        code_acc  = 16'h0000;
    endtask

    // nonzero byte with nothing pending
    task automatic start_byte(input logic [7:0] b);
        if (b < 8'h80) begin
            push_byte(b, 1'b0);
        end else if (b >= 8'hC0 && b < 8'hE0) begin
            seq_kind  = u8cp_pkg::KIND_TWO;
            cont_left = 2'd1;
            code_acc  = {11'd0, b[4:0]};
        end else if (b >= 8'hE0 && b < 8'hF0) begin
            seq_kind  = u8cp_pkg::KIND_THREE;
            cont_left = 2'd2;
            code_acc  = {12'd0, b[3:0]};
        end else if (b >= 8'hF0 && b < 8'hF8) begin
            // four-byte lead: flag it now, drop its continuations later
            push_byte(u8cp_pkg::QMark, 1'b0);
            seq_kind  = u8cp_pkg::KIND_FOUR;
            cont_left = 2'd3;
            code_acc  = 16'h0000;
        end else begin
            // stray continuation or invalid lead
            push_byte(u8cp_pkg::QMark, 1'b0);
        end
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic pending;
        pending = (seq_kind != u8cp_pkg::KIND_NONE) && (cont_left != 2'd0);
        if (!pending)
            clear_decoder();
        if (b == EndByte) begin
            // terminator flushes an open sequence, then closes the string
            if (pending && seq_kind != u8cp_pkg::KIND_FOUR)
                push_byte(u8cp_pkg::QMark, 1'b0);
            push_byte(EndByte, 1'b1);
            clear_decoder();
        end else if (!pending) begin
            start_byte(b);
        end else if (b[7:6] == 2'b10) begin
            cont_left = cont_left - 2'd1;
            if (seq_kind == u8cp_pkg::KIND_FOUR) begin
                if (cont_left == 2'd0)
                    clear_decoder();
            end else begin
                code_acc = {code_acc[9:0], b[5:0]};
                if (cont_left == 2'd0) begin
                    push_byte(cp866_of(code_acc), 1'b0);
                    clear_decoder();
                end
            end
        end else begin
            // sequence cut short: flag it and decode the new byte afresh
            if (seq_kind != u8cp_pkg::KIND_FOUR)
                push_byte(u8cp_pkg::QMark, 1'b0);
            clear_decoder();
            start_byte(b);
        end
    endtask

    // predict on input beats, compare on result beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_decoder();
            cp866_expected.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (cp866_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat data %02h last %b",
                                              m_tdata, m_tlast));
                end else begin
                    want = cp866_expected.pop_front();
                    if (m_tdata !== want.cp866)
                        report_mismatch($sformatf("data %02h, want %02h",
                                                  m_tdata, want.cp866));
                    if (m_tlast !== want.eos)
                        report_mismatch($sformatf("last %b, want %b",
                                                  m_tlast, want.eos));
                end
                results_seen++;
                if (m_tlast === 1'b1)
                    strings_seen++;
            end
        end
        outstanding <= cp866_expected.size();
    end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the utf-8 to cp866 stream recoder
// Drives utf-8 text with random content, malformed and cut-short
// sequences, four-byte leads, overlong forms and terminators, under several
// mixes of sender gaps and receiver stalls plus one long receiver hold.
// The checker alongside predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;

    localparam int         CycleLimit = 400000;
    localparam int         HoldCycles = 300;
    localparam int         DrainWait  = 8;
    localparam logic [7:0] EndByte    = 8'h00;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;            // end_of_string

    int err_count;
    int outstanding;
    int results_seen;
    int strings_seen;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int bytes_sent     = 0;
    int cycle_count    = 0;

    // cyrillic, punctuation, ascii and a few near misses
    logic [7:0] opening_bytes [$] = '{
        8'h41, 8'h7F,
        8'hD0, 8'h90,   8'hD1, 8'h8F,   8'hD0, 8'h81,   8'hD1, 8'h91,
        8'hC2, 8'hA0,
        8'hE2, 8'h80, 8'h94,   8'hE2, 8'h80, 8'hA6,   8'hE2, 8'h82, 8'hAC,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'h80, 8'hFF,
        8'hD0, 8'h41,   8'hF0, 8'h41,
        8'hC0, 8'h80,
        8'hD0, 8'h00
    };

    logic [15:0] punct_codes [$] = '{
        16'h00A0, 16'h2013, 16'h2014, 16'h2018, 16'h2019,
        16'h201C, 16'h201D, 16'h2026, 16'h0401, 16'h0451,
        16'h0400, 16'h0450, 16'h2015, 16'h201A, 16'h201E
    };

    utf8_to_cp866_stream_recoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    cp866_stream_checker scoreboard (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .err_count    (err_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .strings_seen (strings_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, outstanding);
            $display("tb: errors");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold when asked
    initial begin : receiver
        int served;
        served = 0;
        forever begin
            @(posedge aclk);
            if (served != hold_requests) begin
                served = hold_requests;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one input beat, with an optional gap in front of it
    task automatic send_byte(input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // encode a code point in len bytes, sending only the first keep of them
    task automatic send_code(input logic [15:0] cp, input int len, input int keep);
        logic [7:0] seq [3];
        if (len == 2) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
        end else begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
        end
        for (int i = 0; i < keep; i++)
            send_byte(seq[i]);
    endtask

    function automatic logic [15:0] pick_code();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'h0410 + 16'($urandom_range(63));
            4:          return punct_codes[$urandom_range(punct_codes.size() - 1)];
            5:          return 16'h0400 + 16'($urandom_range(16'h5F));
            6:          return 16'h2010 + 16'($urandom_range(16'h1F));
            7:          return 16'($urandom);
            8:          return 16'($urandom_range(16'h7F));
            default:    return 16'h0080 + 16'($urandom_range(16'h077F));
        endcase
    endfunction

    task automatic send_four_byte(input int conts);
        send_byte({5'b11110, 3'($urandom_range(7))});
        repeat (conts) send_byte({2'b10, 6'($urandom)});
    endtask

    // mostly well-formed text, the rest broken sequences and noise
    task automatic random_traffic(input int n);
        int target;
        int r;
        int len;
        logic [15:0] cp;
        target = bytes_sent + n;
        while (bytes_sent < target) begin
            r   = $urandom_range(99);
            cp  = pick_code();
            len = (cp < 16'h0800 && $urandom_range(99) < 85) ? 2 : 3;
            if (r < 35)
                send_byte(8'($urandom_range(1, 127)));
            else if (r < 70)
                send_code(cp, len, len);
            else if (r < 76)
                send_four_byte(3);
            else if (r < 80)
                send_byte(EndByte);
            else if (r < 88)
                send_code(cp, len, $urandom_range(1, len - 1));
            else if (r < 92)
                send_four_byte($urandom_range(2));
            else
                send_byte(8'($urandom));
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);

        // idle mixes: none, sender only, receiver only, both
        send_idle_pct = 0;  recv_stall_pct = 0;  random_traffic(210);
        send_idle_pct = 66; recv_stall_pct = 0;  random_traffic(210);
        send_idle_pct = 0;  recv_stall_pct = 66; random_traffic(210);
        send_idle_pct = 25; recv_stall_pct = 25; random_traffic(210);

        // long receiver hold while the sender keeps offering beats
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_requests++;
        random_traffic(100);
        random_traffic(100);
        send_byte(EndByte);
        s_tvalid <= 1'b0;

        // let the checker count the last beat before waiting on it
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);

        $display("sent %0d utf-8 bytes, checked %0d cp866 beats over %0d strings",
                 bytes_sent, results_seen, strings_seen);
        $display("idle mixes: none, sender, receiver, both; one long receiver hold");
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
